// ===== hdl/pmpa_pkg.sv =====
package pmpa_pkg;

    // Device type codes reported by the mouse identify sequence
    localparam logic [7:0] DEV_PLAIN       = 8'd0;
    localparam logic [7:0] DEV_WHEEL       = 8'd3;
    localparam logic [7:0] DEV_WHEEL5      = 8'd4;
    localparam logic [7:0] DEV_TYPE_RESET  = 8'hFF;

    // Command codes on the input channel
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Packet framing
    localparam int           PKT_DEPTH   = 3;
    localparam logic [1:0]   LAST_PLAIN  = 2'd2;
    localparam logic [1:0]   LAST_WHEEL  = 2'd3;
    localparam int           SYNC_BIT    = 3;
    localparam int           X_SIGN_BIT  = 4;
    localparam int           Y_SIGN_BIT  = 5;

    // Saturation limits of the accumulators
    localparam logic signed [9:0] AXIS_MAX = 10'sd127;
    localparam logic signed [9:0] AXIS_MIN = -10'sd128;

    typedef logic signed [7:0] axis_t;
    typedef logic signed [8:0] delta_t;
    typedef logic [4:0]        buttons_t;
    typedef logic [7:0]        byte_t;

    // Add a signed delta to an accumulator and clamp to the 8-bit range
    function automatic axis_t sat_add(input axis_t acc, input delta_t d);
        logic signed [9:0] sum;
        sum = 10'(signed'({{2{acc[7]}}, acc})) + 10'(signed'({d[8], d}));
        if (sum > AXIS_MAX) begin
            sum = AXIS_MAX;
        end
        else if (sum < AXIS_MIN) begin
            sum = AXIS_MIN;
        end
        return sum[7:0];
    endfunction

endpackage

// ===== hdl/pmpa_if.sv =====
interface pmpa_in_if import pmpa_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    byte_t data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface pmpa_out_if import pmpa_pkg::*; ();
    logic     valid;
    logic     ready;
    buttons_t buttons;
    axis_t    motion_x;
    axis_t    motion_y;
    axis_t    motion_wheel;
    logic     packet_done;

    modport source (output valid, output buttons, output motion_x, output motion_y,
                    output motion_wheel, output packet_done, input ready);
    modport sink   (input valid, input buttons, input motion_x, input motion_y,
                    input motion_wheel, input packet_done, output ready);
endinterface

interface pmpa_cfg_if import pmpa_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t device_type;

    modport source (output valid, output device_type, input ready);
    modport sink   (input valid, input device_type, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_accumulator_core.sv =====
// Mouse packet accumulator: frames mouse bytes into 3-byte (type 0) or 4-byte
// (types 3 and 4) packets, adds each packet's X, Y and wheel deltas into
// saturating 8-bit accumulators and keeps a 5-bit button word; a read beat
// (cmd = 1) reports the sums and clears them. Every input beat gives exactly
// one report beat. One beat is taken per clock unless the report channel
// stalls; each beat passes through the input register, then the result
// register, where the single saturating add per axis sits. Backpressure on
// the report channel holds the result register, then the input register.
// The device_type register is written through the cfg channel, always ready,
// and must only change while no beat is in flight.
module ps2_mouse_packet_accumulator_core
    import pmpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pmpa_cfg_if.sink   cfg,
    pmpa_in_if.sink    mouse_in,
    pmpa_out_if.source report_out
);

    // Input register
    logic  in_valid_reg;
    logic  in_cmd_reg;
    byte_t in_data_reg;

    // Result register
    logic     out_valid_reg;
    buttons_t out_buttons_reg;
    axis_t    out_x_reg;
    axis_t    out_y_reg;
    axis_t    out_wheel_reg;
    logic     out_done_reg;

    // Block state
    byte_t    dev_type_reg;
    logic [1:0] byte_idx_reg;
    logic [1:0] byte_idx_next;
    byte_t    pkt_reg [PKT_DEPTH];
    axis_t    sum_x_reg, sum_y_reg, sum_wheel_reg;
    axis_t    sum_x_next, sum_y_next, sum_wheel_next;
    buttons_t btn_reg, btn_next;

    logic       out_free;
    logic       advance;
    logic       type_ok;
    logic       is_plain;
    logic       sync_drop;
    logic       take;
    logic       complete;
    logic       store;
    logic [1:0] last_idx;
    delta_t     dx, dy, dz;
    logic [1:0] extra;
    axis_t      new_x, new_y, new_wheel;
    byte_t      y_byte;

    assign out_free       = !out_valid_reg || report_out.ready;
    assign advance        = in_valid_reg && out_free;
    assign mouse_in.ready = !in_valid_reg || out_free;
    assign cfg.ready      = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dev_type_reg <= DEV_TYPE_RESET;
        end
        else if (cfg.valid) begin
            dev_type_reg <= cfg.device_type;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (mouse_in.ready) begin
            in_valid_reg <= mouse_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mouse_in.valid && mouse_in.ready) begin
            in_cmd_reg  <= mouse_in.cmd;
            in_data_reg <= mouse_in.data_byte;
        end
    end

    // Decode the framer action for the held byte
    always_comb
    begin
        type_ok   = (dev_type_reg == DEV_PLAIN) || (dev_type_reg == DEV_WHEEL) ||
                    (dev_type_reg == DEV_WHEEL5);
        is_plain  = (dev_type_reg == DEV_PLAIN);
        last_idx  = is_plain ? LAST_PLAIN : LAST_WHEEL;
        sync_drop = (byte_idx_reg == 2'd0) && !in_data_reg[SYNC_BIT];
        take      = (in_cmd_reg == CMD_BYTE) && type_ok && !sync_drop;
        complete  = take && (byte_idx_reg >= last_idx);
        store     = take && !complete;
    end

    // Form the packet deltas
    always_comb
    begin
        y_byte = is_plain ? in_data_reg : pkt_reg[2];
        dx     = signed'({pkt_reg[0][X_SIGN_BIT], pkt_reg[1]});
        dy     = signed'({pkt_reg[0][Y_SIGN_BIT], y_byte});
        dz     = '0;
        extra  = 2'b00;
        if (dev_type_reg == DEV_WHEEL) begin
            dz = signed'({in_data_reg[7], in_data_reg});
        end
        else if (dev_type_reg == DEV_WHEEL5) begin
            dz    = signed'({{5{in_data_reg[3]}}, in_data_reg[3:0]});
            extra = in_data_reg[5:4];
        end
        new_x     = sat_add(sum_x_reg, dx);
        new_y     = sat_add(sum_y_reg, dy);
        new_wheel = sat_add(sum_wheel_reg, dz);
    end

    // Next state of the framer and accumulators
    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_wheel_next = sum_wheel_reg;
        btn_next       = btn_reg;
        if (in_cmd_reg == CMD_READ) begin
            sum_x_next     = '0;
            sum_y_next     = '0;
            sum_wheel_next = '0;
        end
        else if (complete) begin
            byte_idx_next  = 2'd0;
            sum_x_next     = new_x;
            sum_y_next     = new_y;
            sum_wheel_next = new_wheel;
            btn_next       = {extra, pkt_reg[0][2:0]};
        end
        else if (store) begin
            byte_idx_next = byte_idx_reg + 2'd1;
        end
    end

    // Advance the state when the held beat moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_idx_reg  <= 2'd0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_wheel_reg <= '0;
            btn_reg       <= '0;
        end
        else if (advance) begin
            byte_idx_reg  <= byte_idx_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_wheel_reg <= sum_wheel_next;
            btn_reg       <= btn_next;
        end
    end

    // Packet byte store; the last byte of a plain packet lands in entry 2
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PKT_DEPTH; i++) begin
            if (advance && (store || (complete && is_plain)) &&
                (byte_idx_reg == 2'(i) || (complete && i == PKT_DEPTH - 1))) begin
                pkt_reg[i] <= in_data_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_done_reg <= complete;
            if (in_cmd_reg == CMD_READ) begin
                out_buttons_reg <= btn_reg;
                out_x_reg       <= sum_x_reg;
                out_y_reg       <= sum_y_reg;
                out_wheel_reg   <= sum_wheel_reg;
            end
            else begin
                out_buttons_reg <= btn_next;
                out_x_reg       <= sum_x_next;
                out_y_reg       <= sum_y_next;
                out_wheel_reg   <= sum_wheel_next;
            end
        end
    end

    assign report_out.valid        = out_valid_reg;
    assign report_out.buttons      = out_buttons_reg;
    assign report_out.motion_x     = out_x_reg;
    assign report_out.motion_y     = out_y_reg;
    assign report_out.motion_wheel = out_wheel_reg;
    assign report_out.packet_done  = out_done_reg;

endmodule

// ===== hdl/pmpa_checker.sv =====
module pmpa_checker
    import pmpa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input buttons_t buttons,
    input axis_t    motion_x,
    input axis_t    motion_y,
    input axis_t    motion_wheel,
    input logic     packet_done
);

    // Hold a stalled report beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(buttons) && $stable(motion_x) &&
        $stable(motion_y) && $stable(motion_wheel) && $stable(packet_done))
        else $error("report beat changed while stalled");

    // Every accepted beat yields a report from the result register, or one is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted beat produced no report");

    // A fresh report always traces back to an input beat held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("report appeared without an input beat");

    // Input stalls only when a report is waiting and not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind ps2_mouse_packet_accumulator_core pmpa_checker u_pmpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mouse_in.valid),
    .in_ready     (mouse_in.ready),
    .out_valid    (report_out.valid),
    .out_ready    (report_out.ready),
    .buttons      (report_out.buttons),
    .motion_x     (report_out.motion_x),
    .motion_y     (report_out.motion_y),
    .motion_wheel (report_out.motion_wheel),
    .packet_done  (report_out.packet_done)
);
